FILE: hw/rtl/lqg_pkg.sv
// ----------------------------------------------------------------------------
// lqg_pkg
// Shared constants, coefficients and command types of the LQG observer block.
// ----------------------------------------------------------------------------
package lqg_pkg;

   localparam int STATE_ORDER_DEFAULT   = 4;
   localparam int FRACTION_BITS_DEFAULT = 12;
   localparam int COEF_BITS             = 24;
   localparam int ACC_W                 = 64;

   // Controller modes; the spare code runs the PID controller.
   localparam logic [1:0] MODE_LQG   = 2'd0;
   localparam logic [1:0] MODE_LQR   = 2'd1;
   localparam logic [1:0] MODE_PID   = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Multiply-accumulate operand selects.
   localparam logic [3:0] OPA_X0   = 4'd0;
   localparam logic [3:0] OPA_X1   = 4'd1;
   localparam logic [3:0] OPA_X2   = 4'd2;
   localparam logic [3:0] OPA_X3   = 4'd3;
   localparam logic [3:0] OPA_UPRV = 4'd4;
   localparam logic [3:0] OPA_INNV = 4'd5;
   localparam logic [3:0] OPA_ERR  = 4'd6;
   localparam logic [3:0] OPA_INTG = 4'd7;
   localparam logic [3:0] OPA_DERR = 4'd8;

   // Prediction coefficients A*dt (row-major) and B*dt, 24 fraction bits.
   function automatic logic signed [25:0] pred_coef(input logic [1:0] i, input logic [1:0] j);
      logic signed [25:0] c;
      c = '0;
      case ({i, j})
         4'b0001: c = 26'sd167772;
         4'b0100: c = -26'sd83886;
         4'b0101: c = -26'sd50332;
         4'b0110: c = 26'sd16777;
         4'b1001: c = 26'sd33554;
         4'b1010: c = -26'sd33554;
         4'b1011: c = 26'sd8389;
         4'b1110: c = 26'sd16777;
         4'b1111: c = -26'sd25166;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [25:0] drive_coef(input logic [1:0] i);
      return (i == 2'd1) ? 26'sd83886 : 26'sd0;
   endfunction

   // Negated feedback gains -K.
   function automatic logic signed [25:0] neg_gain_k(input logic [1:0] i);
      logic signed [25:0] c;
      case (i)
         2'd0:    c = -26'sd13814360;
         2'd1:    c = -26'sd5798206;
         2'd2:    c = -26'sd2162583;
         default: c = -26'sd1082130;
      endcase
      return c;
   endfunction

   function automatic logic signed [25:0] gain_l(input logic [1:0] i);
      logic signed [25:0] c;
      case (i)
         2'd0:    c = 26'sd4120484;
         2'd1:    c = 26'sd3076941;
         2'd2:    c = 26'sd1530082;
         default: c = 26'sd765041;
      endcase
      return c;
   endfunction

   localparam logic signed [25:0] PID_P  = 26'sd13421773;
   localparam logic signed [25:0] PID_I  = 26'sd2516582;
   localparam logic signed [25:0] PID_DT = 26'sd167772;
   // The derivative gain of 5 with 24 fraction bits needs 28 bits.
   localparam logic signed [27:0] PID_D  = 28'sd5 <<< COEF_BITS;

   // Datapath writeback targets.
   localparam logic [2:0] WB_NONE = 3'd0;
   localparam logic [2:0] WB_XP   = 3'd1;
   localparam logic [2:0] WB_EST  = 3'd2;
   localparam logic [2:0] WB_INTG = 3'd3;
   localparam logic [2:0] WB_U    = 3'd4;

   typedef struct packed {
      logic       clear;     // start a new sum
      logic [3:0] opa;       // operand select
      logic [1:0] idx;       // coefficient row/column
      logic [2:0] coef_sel;  // coefficient family
      logic       mac;       // accumulate a product
      logic [2:0] wb;        // writeback of rounded sum
      logic [1:0] wb_idx;
      logic       load;      // capture input item
      logic       commit;    // commit new states, form outputs
      logic [1:0] mode;
   } cmd_type;

   localparam logic [2:0] CS_PRED  = 3'd0;
   localparam logic [2:0] CS_DRV   = 3'd1;
   localparam logic [2:0] CS_K     = 3'd2;
   localparam logic [2:0] CS_L     = 3'd3;
   localparam logic [2:0] CS_P     = 3'd4;
   localparam logic [2:0] CS_I     = 3'd5;
   localparam logic [2:0] CS_D     = 3'd6;
   localparam logic [2:0] CS_DT    = 3'd7;

   // Round a 24-fraction-bit sum to nearest: floor(v/2^24 + 1/2).
   function automatic logic signed [ACC_W-1:0] round_coef(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = v + (64'sd1 <<< (COEF_BITS - 1));
      return t >>> COEF_BITS;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767)       r = 16'sh7fff;
      else if (v < -64'sd32768) r = 16'sh8000;
      else                      r = v[15:0];
      return r;
   endfunction

endpackage

FILE: hw/rtl/lqg_stream_if.sv
// ----------------------------------------------------------------------------
// lqg_stream_if
// Valid/ready channels for control-step items and results.
// ----------------------------------------------------------------------------
interface lqg_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] lambda_measured;
   logic signed [15:0] lambda_deviation;
   modport source (output valid, lambda_measured, lambda_deviation, input ready);
   modport sink   (input valid, lambda_measured, lambda_deviation, output ready);
endinterface

interface lqg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [13:0] drive;
   logic        [7:0]  pwm_duty;
   logic        [9:0]  injector_command;
   logic        [15:0] step_number;
   modport source (output valid, drive, pwm_duty, injector_command, step_number,
                   input ready);
   modport sink   (input valid, drive, pwm_duty, injector_command, step_number,
                   output ready);
endinterface

FILE: hw/rtl/lqg_datapath.sv
// ----------------------------------------------------------------------------
// lqg_datapath
// State registers and one shared multiply-accumulate unit with rounding.
// ----------------------------------------------------------------------------
module lqg_datapath #(
   parameter int FRACTION_BITS = lqg_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  lqg_pkg::cmd_type   cmd,
   input  logic signed [15:0] in_y,
   input  logic signed [15:0] in_e,
   output logic signed [13:0] drive,
   output logic        [7:0]  pwm_duty,
   output logic        [9:0]  injector_command,
   output logic        [15:0] step_number
);

   localparam logic signed [63:0] ONE  = 64'sd1 <<< FRACTION_BITS;
   localparam logic signed [63:0] HALF = ONE >>> 1;

   logic signed [15:0] est_ff [4];
   logic signed [15:0] fbs_ff [4];
   logic signed [15:0] xp_ff  [4];
   logic signed [15:0] nxt_ff [4];
   logic signed [15:0] intg_ff, intg_new_ff, perr_ff, pdrv_ff;
   logic        [15:0] step_ff;
   logic signed [15:0] y_ff, e_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] u_ff;
   logic signed [16:0] innov;
   logic signed [16:0] derr;
   logic signed [16:0] opa;
   logic signed [27:0] coef;
   logic signed [44:0] prod;
   logic signed [63:0] acc_in;
   logic signed [63:0] rnd;
   logic signed [63:0] up;
   logic        [63:0] pwm_w, cmd_w;

   assign innov = 17'(y_ff) - 17'(xp_ff[0]);
   assign derr  = 17'(e_ff) - 17'(perr_ff);

   // Operand select: prediction uses the selected mode's current state.
   always_comb begin
      opa = '0;
      case (cmd.opa)
         lqg_pkg::OPA_X0, lqg_pkg::OPA_X1, lqg_pkg::OPA_X2, lqg_pkg::OPA_X3: begin
            if (cmd.coef_sel == lqg_pkg::CS_K)
               opa = 17'(nxt_ff[cmd.opa[1:0]]);
            else if (cmd.mode == lqg_pkg::MODE_LQG)
               opa = 17'(est_ff[cmd.opa[1:0]]);
            else
               opa = 17'(fbs_ff[cmd.opa[1:0]]);
         end
         lqg_pkg::OPA_UPRV: opa = 17'(pdrv_ff);
         lqg_pkg::OPA_INNV: opa = innov;
         lqg_pkg::OPA_ERR:  opa = 17'(e_ff);
         lqg_pkg::OPA_INTG: opa = 17'(intg_new_ff);
         lqg_pkg::OPA_DERR: opa = derr;
         default:           opa = '0;
      endcase
   end

   always_comb begin
      case (cmd.coef_sel)
         lqg_pkg::CS_PRED: coef = 28'(lqg_pkg::pred_coef(cmd.wb_idx, cmd.idx));
         lqg_pkg::CS_DRV:  coef = 28'(lqg_pkg::drive_coef(cmd.wb_idx));
         lqg_pkg::CS_K:    coef = 28'(lqg_pkg::neg_gain_k(cmd.idx));
         lqg_pkg::CS_L:    coef = 28'(lqg_pkg::gain_l(cmd.idx));
         lqg_pkg::CS_P:    coef = 28'(lqg_pkg::PID_P);
         lqg_pkg::CS_I:    coef = 28'(lqg_pkg::PID_I);
         lqg_pkg::CS_D:    coef = lqg_pkg::PID_D;
         default:          coef = 28'(lqg_pkg::PID_DT);
      endcase
   end

   assign prod   = 45'(coef) * 45'(opa);
   assign acc_in = (cmd.clear ? 64'sd0 : acc_ff) + (cmd.mac ? 64'(prod) : 64'sd0);
   assign rnd    = lqg_pkg::round_coef(acc_ff);

   // Accumulator and sequenced writebacks.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.load) begin
         y_ff <= in_y;
         e_ff <= in_e;
      end
      case (cmd.wb)
         lqg_pkg::WB_XP:   xp_ff[cmd.wb_idx] <= lqg_pkg::sat16(rnd);
         lqg_pkg::WB_EST:  nxt_ff[cmd.wb_idx] <= lqg_pkg::sat16(64'(xp_ff[cmd.wb_idx]) + rnd);
         lqg_pkg::WB_INTG: begin
            if (64'(intg_ff) + rnd > HALF)       intg_new_ff <= lqg_pkg::sat16(HALF);
            else if (64'(intg_ff) + rnd < -HALF) intg_new_ff <= lqg_pkg::sat16(-HALF);
            else intg_new_ff <= lqg_pkg::sat16(64'(intg_ff) + rnd);
         end
         lqg_pkg::WB_U: begin
            if (rnd > ONE)       u_ff <= ONE;
            else if (rnd < -ONE) u_ff <= -ONE;
            else                 u_ff <= rnd;
         end
         default: ;
      endcase
      // LQR: next state is the prediction with state 0 replaced by the error.
      if (cmd.wb == lqg_pkg::WB_XP && cmd.mode == lqg_pkg::MODE_LQR)
         nxt_ff[cmd.wb_idx] <= (cmd.wb_idx == 2'd0) ? e_ff : lqg_pkg::sat16(rnd);
   end

   assign up    = u_ff + ONE;
   assign pwm_w = (64'(up) * 64'd255) >> (FRACTION_BITS + 1);
   assign cmd_w = (64'(up) * 64'd500) >> FRACTION_BITS;

   // State commit at the end of a step.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            est_ff[i] <= '0;
            fbs_ff[i] <= '0;
         end
         intg_ff <= '0;
         perr_ff <= '0;
         pdrv_ff <= '0;
         step_ff <= '0;
      end else if (cmd.commit) begin
         case (cmd.mode)
            lqg_pkg::MODE_LQG: for (int i = 0; i < 4; i++) est_ff[i] <= nxt_ff[i];
            lqg_pkg::MODE_LQR: for (int i = 0; i < 4; i++) fbs_ff[i] <= nxt_ff[i];
            default: begin
               intg_ff <= intg_new_ff;
               perr_ff <= e_ff;
            end
         endcase
         pdrv_ff          <= lqg_pkg::sat16(u_ff);
         drive            <= u_ff[13:0];
         pwm_duty         <= (pwm_w > 64'd255) ? 8'd255 : pwm_w[7:0];
         injector_command <= (cmd_w > 64'd1000) ? 10'd1000 : cmd_w[9:0];
         step_number      <= step_ff;
         step_ff          <= step_ff + 16'd1;
      end
   end

endmodule

FILE: hw/rtl/lqg_controller.sv
// ----------------------------------------------------------------------------
// lqg_controller
// Sequencer issuing multiply-accumulate commands for one control step.
// ----------------------------------------------------------------------------
module lqg_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       mode,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output lqg_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRED = 3'd1;
   localparam logic [2:0] ST_CORR = 3'd2;
   localparam logic [2:0] ST_FB   = 3'd3;
   localparam logic [2:0] ST_PID  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] mode_ff, mode_in;
   logic       ov_ff, ov_in;

   // One step is running while the state is not idle; results wait in ST_OUT.
   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = ov_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;
      ov_in    = ov_ff;
      cmd      = '0;
      cmd.mode = mode_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               mode_in  = mode;
               cnt_in   = '0;
               state_in = (mode == lqg_pkg::MODE_LQG || mode == lqg_pkg::MODE_LQR)
                          ? ST_PRED : ST_PID;
            end
         end
         // Per row: clear, four state products, one drive product, writeback.
         ST_PRED: begin
            cmd.wb_idx = cnt_ff[3:2];
            cmd.coef_sel = lqg_pkg::CS_PRED;
            cmd.idx = cnt_ff[1:0];
            cmd.opa = {2'b00, cnt_ff[1:0]};
            cmd.mac = 1'b1;
            cmd.clear = (cnt_ff[1:0] == 2'd0);
            if (cnt_ff[1:0] == 2'd3) state_in = ST_CORR;
            cnt_in = cnt_ff + 4'd1;
         end
         ST_CORR: begin
            // Drive-input product, then writeback of the predicted row.
            cmd.wb_idx   = cnt_ff[3:2] - 2'd1;
            cmd.coef_sel = lqg_pkg::CS_DRV;
            cmd.opa      = lqg_pkg::OPA_UPRV;
            cmd.mac      = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            cmd.wb_idx = cnt_ff[3:2] - 2'd1;
            cmd.wb     = lqg_pkg::WB_XP;
            state_in   = (cnt_ff == 4'd0) ?
                         ((mode_ff == lqg_pkg::MODE_LQG) ? ST_FB : ST_FB) : ST_PRED;
            cnt_in     = cnt_ff;
            if (cnt_ff == 4'd0 && mode_ff == lqg_pkg::MODE_LQG) cnt_in = 4'd8;
         end
         ST_FB: begin
            // LQG correction (counts 8..15: mac, writeback) then feedback 0..4.
            if (cnt_ff[3]) begin
               cmd.wb_idx = cnt_ff[2:1];
               cmd.idx = cnt_ff[2:1];
               cmd.coef_sel = lqg_pkg::CS_L;
               cmd.opa = lqg_pkg::OPA_INNV;
               if (!cnt_ff[0]) begin
                  cmd.clear = 1'b1;
                  cmd.mac = 1'b1;
               end else cmd.wb = lqg_pkg::WB_EST;
               cnt_in = (cnt_ff == 4'd15) ? 4'd0 : cnt_ff + 4'd1;
            end else if (cnt_ff < 4'd4) begin
               cmd.coef_sel = lqg_pkg::CS_K;
               cmd.idx = cnt_ff[1:0];
               cmd.opa = {2'b00, cnt_ff[1:0]};
               cmd.mac = 1'b1;
               cmd.clear = (cnt_ff == 4'd0);
               cnt_in = cnt_ff + 4'd1;
            end else begin
               cmd.wb = lqg_pkg::WB_U;
               state_in = ST_OUT;
               cnt_in = '0;
            end
         end
         ST_PID: begin
            case (cnt_ff)
               4'd0: begin
                  cmd.coef_sel = lqg_pkg::CS_DT; cmd.opa = lqg_pkg::OPA_ERR;
                  cmd.clear = 1'b1; cmd.mac = 1'b1;
               end
               4'd1: cmd.wb = lqg_pkg::WB_INTG;
               4'd2: begin
                  cmd.coef_sel = lqg_pkg::CS_P; cmd.opa = lqg_pkg::OPA_ERR;
                  cmd.clear = 1'b1; cmd.mac = 1'b1;
               end
               4'd3: begin
                  cmd.coef_sel = lqg_pkg::CS_I; cmd.opa = lqg_pkg::OPA_INTG; cmd.mac = 1'b1;
               end
               4'd4: begin
                  cmd.coef_sel = lqg_pkg::CS_D; cmd.opa = lqg_pkg::OPA_DERR; cmd.mac = 1'b1;
               end
               default: begin
                  cmd.wb = lqg_pkg::WB_U;
                  state_in = ST_OUT;
               end
            endcase
            cnt_in = (cnt_ff == 4'd5) ? 4'd0 : cnt_ff + 4'd1;
         end
         ST_OUT: begin
            // Commit once, then hold the result until its transfer.
            if (!ov_ff) begin
               cmd.commit = 1'b1;
               ov_in = 1'b1;
            end else if (out_ready) begin
               ov_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
         ov_ff    <= ov_in;
      end
   end

endmodule

FILE: hw/rtl/lqg_observer_controller.sv
// ----------------------------------------------------------------------------
// lqg_observer_controller
// Every product of a control step, in LQG, LQR and PID mode alike, goes through
// the one shared multiply-accumulate unit in turn.
// One item at a time: a new input is taken only after the result of the last
// one has been transferred, so a waiting result holds the input off.
// Reset clears all controller states, the step count and the mode register.
// ----------------------------------------------------------------------------
module lqg_observer_controller #(
   parameter int FRACTION_BITS = lqg_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lqg_req_if.sink    req,
   lqg_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   logic [1:0]       mode_ff;
   lqg_pkg::cmd_type cmd;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= lqg_pkg::MODE_LQG;
      else if (csr_write_enable) mode_ff <= csr_write_data;
   end

   lqg_controller u_ctrl (
      .clock, .reset, .mode(mode_ff),
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .cmd
   );

   lqg_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock, .reset, .cmd,
      .in_y(req.lambda_measured), .in_e(req.lambda_deviation),
      .drive(rsp.drive), .pwm_duty(rsp.pwm_duty),
      .injector_command(rsp.injector_command), .step_number(rsp.step_number)
   );

   // A result is never shown while a new item is being taken.
   assert property (@(posedge clock) disable iff (reset) !(rsp.valid && req.ready))
      else $error("result valid while accepting input");
   // Result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.step_number))
      else $error("result changed before transfer");

endmodule

FILE: bench/lqg_observer_controller_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lqg_observer_controller_checker
// Watches the step and result channels, predicts every result of the
// controller and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module lqg_observer_controller_checker (
   input  logic       clock,
   input  logic       reset,
   lqg_req_if         req,
   lqg_rsp_if         rsp,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data,
   output int         failures,
   output int         pending,
   output int         results_seen
);

   localparam int FB = lqg_pkg::FRACTION_BITS_DEFAULT;

   typedef struct packed {
      logic signed [13:0] drive;
      logic [7:0]         pwm_duty;
      logic [9:0]         injector_command;
      logic [15:0]        step_number;
   } step_result_type;

   typedef logic signed [63:0] wide_type;

   // Predictor state.
   wide_type    est [4];
   wide_type    fbk [4];
   wide_type    integ, prev_err, prev_u;
   logic [15:0] steps;
   logic [1:0]  mode;

   step_result_type expected_results[$];

   // Floor(v / 2^24 + 1/2).
   function automatic wide_type rnd(input wide_type v);
      wide_type t;
      t = v + (64'sd1 <<< 23);
      return t >>> 24;
   endfunction

   function automatic wide_type lim(input wide_type v, input wide_type lo, input wide_type hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic wide_type a_coef(input int i, input int j);
      wide_type c [16] = '{0, 167772, 0, 0, -83886, -50332, 16777, 0,
                           0, 33554, -33554, 8389, 0, 0, 16777, -25166};
      return c[i * 4 + j];
   endfunction

   function automatic wide_type k_coef(input int i);
      wide_type c [4] = '{13814360, 5798206, 2162583, 1082130};
      return c[i];
   endfunction

   function automatic wide_type l_coef(input int i);
      wide_type c [4] = '{4120484, 3076941, 1530082, 765041};
      return c[i];
   endfunction

   // Advance the predictor by one control step and return the result.
   function automatic step_result_type control_step(input wide_type y, input wide_type e);
      wide_type        xp [4];
      wide_type        acc, innov, u, one, up;
      step_result_type r;
      one = 64'sd1 <<< FB;
      if (mode == lqg_pkg::MODE_LQG || mode == lqg_pkg::MODE_LQR) begin
         for (int i = 0; i < 4; i++) begin
            acc = (i == 1) ? 64'sd83886 * prev_u : 0;
            for (int j = 0; j < 4; j++)
               acc += a_coef(i, j) * ((mode == lqg_pkg::MODE_LQG) ? est[j] : fbk[j]);
            xp[i] = lim(rnd(acc), -32768, 32767);
         end
         if (mode == lqg_pkg::MODE_LQG) begin
            innov = y - xp[0];
            for (int i = 0; i < 4; i++)
               est[i] = lim(xp[i] + rnd(l_coef(i) * innov), -32768, 32767);
         end else begin
            xp[0] = e;
            for (int i = 0; i < 4; i++) fbk[i] = xp[i];
         end
         acc = 0;
         for (int i = 0; i < 4; i++)
            acc -= k_coef(i) * ((mode == lqg_pkg::MODE_LQG) ? est[i] : fbk[i]);
         u = lim(rnd(acc), -one, one);
      end else begin
         // PID, also taken by the unused mode code.
         integ = lim(integ + rnd(64'sd167772 * e), -(one >>> 1), one >>> 1);
         acc = 64'sd13421773 * e + 64'sd2516582 * integ + ((e - prev_err) <<< 24) * 5;
         prev_err = e;
         u = lim(rnd(acc), -one, one);
      end
      prev_u = u;
      up = u + one;
      r.drive            = u[13:0];
      r.pwm_duty         = 8'(lim((up * 255) >>> (FB + 1), 0, 255));
      r.injector_command = 10'(lim((up * 500) >>> FB, 0, 1000));
      r.step_number      = steps;
      steps++;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at step %0d: %s got %0d expected %0d", results_seen, what, got, want);
      failures++;
   endtask

   step_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            est[i] = 0;
            fbk[i] = 0;
         end
         integ = 0;
         prev_err = 0;
         prev_u = 0;
         steps = 0;
         mode = lqg_pkg::MODE_LQG;
         expected_results.delete();
         failures = 0;
         results_seen = 0;
      end else begin
         // Compare a result transfer with the oldest expectation.
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result, step_number", rsp.step_number, -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp.drive !== want.drive)
                  report_mismatch("drive", rsp.drive, want.drive);
               if (rsp.pwm_duty !== want.pwm_duty)
                  report_mismatch("pwm_duty", rsp.pwm_duty, want.pwm_duty);
               if (rsp.injector_command !== want.injector_command)
                  report_mismatch("injector_command", rsp.injector_command,
                                  want.injector_command);
               if (rsp.step_number !== want.step_number)
                  report_mismatch("step_number", rsp.step_number, want.step_number);
            end
            results_seen++;
         end
         // A step transfer adds one expectation.
         if (req.valid && req.ready)
            expected_results.push_back(control_step(req.lambda_measured,
                                                    req.lambda_deviation));
         if (csr_write_enable) mode = csr_write_data;
      end
      pending = expected_results.size();
   end

endmodule

FILE: bench/tb_lqg_observer_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lqg_observer_controller
// Drives control steps through every controller mode with random idling
// on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lqg_observer_controller;

   localparam int LIMIT = 20000;

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_write_enable = 0;
   logic [1:0] csr_write_data = '0;
   int         failures, pending, results_seen;
   int         send_idle = 0, take_stall = 0;
   bit         hold_off = 0;
   int         idle_cycles = 0;
   int         steps_sent = 0;

   lqg_req_if req ();
   lqg_rsp_if rsp ();

   lqg_observer_controller dut (
      .clock, .reset, .req, .rsp,
      .csr_write_enable, .csr_write_data
   );

   lqg_observer_controller_checker checker_inst (
      .clock, .reset, .req, .rsp,
      .csr_write_enable, .csr_write_data,
      .failures, .pending, .results_seen
   );

   always #10 clock = ~clock;

   initial begin
      req.valid = 0;
      req.lambda_measured = '0;
      req.lambda_deviation = '0;
      rsp.ready = 0;
   end

   // Receiver: random stalls, or a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 0;
      else rsp.ready <= !hold_off && ($urandom_range(99) >= take_stall);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("FAIL lqg_observer_controller");
         $finish;
      end
   end

   // One step transfer; the sender may idle first, and valid stays high
   // after the transfer until the next step or a drain lowers it.
   task automatic send_step(input logic signed [15:0] y, input logic signed [15:0] e);
      if ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req.valid <= 1;
      req.lambda_measured <= y;
      req.lambda_deviation <= e;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      steps_sent++;
   endtask

   task automatic drain;
      req.valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic signed [15:0] rand_value();
      case ($urandom_range(5))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(1000) - 500);
         3:       return 16'($urandom_range(8192) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [1:0]         modes [4] = '{lqg_pkg::MODE_LQG, lqg_pkg::MODE_LQR,
                                        lqg_pkg::MODE_PID, lqg_pkg::MODE_SPARE};
      logic signed [15:0] edges [5] = '{16'sh7fff, 16'sh8000, 0, 16'sh1000, -16'sh1000};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes in each mode, including the unused code.
      foreach (modes[m]) begin
         set_mode(modes[m]);
         foreach (edges[i]) send_step(edges[i], edges[4 - i]);
      end

      // Random phases over modes and idling patterns.
      for (int phase = 0; phase < 12; phase++) begin
         set_mode(phase % 3 == 0 ? lqg_pkg::MODE_LQG :
                  (phase % 3 == 1 ? lqg_pkg::MODE_LQR : lqg_pkg::MODE_PID));
         case (phase % 4)
            0: begin send_idle = 0;  take_stall = 0;  end
            1: begin send_idle = 60; take_stall = 0;  end
            2: begin send_idle = 0;  take_stall = 60; end
            default: begin send_idle = 24; take_stall = 24; end
         endcase
         if (phase == 5) begin
            // Long receiver hold-off while steps keep coming.
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(posedge clock);
                  hold_off = 0;
               end
               repeat (6) send_step(rand_value(), rand_value());
            join
         end
         repeat (48) send_step(rand_value(), rand_value());
         // In phase 7, pause until all results are back, then carry on.
         if (phase == 7) drain();
      end
      set_mode(lqg_pkg::MODE_SPARE);
      send_idle = 0;
      take_stall = 0;
      repeat (10) send_step(rand_value(), rand_value());

      drain();
      $display("covered %0d steps and %0d results across LQG, LQR, PID and the spare code,",
               steps_sent, results_seen);
      $display("with sender gaps, receiver stalls and a long result hold-off");
      if (failures == 0)
         $display("PASS lqg_observer_controller");
      else
         $display("FAIL lqg_observer_controller");
      $finish;
   end
endmodule
